// File: sv/shbi_pkg.sv
// Package with the types and constants of the string hash bucket index block.
package shbi_pkg;

  // Widths of the word fields and of the configuration register.
  localparam int unsigned KeyW    = 8;
  localparam int unsigned HashW   = 62;
  localparam int unsigned BucketW = 32;
  localparam int unsigned ProdW   = 64;

  // The modulus 2^61 + 15 splits a 64-bit value at bit 61.
  localparam int unsigned SplitW = 61;
  localparam logic [ProdW-1:0] HashModulus = (64'd1 << 61) + 64'd15;
  localparam logic [3:0] FoldFactor = 4'd15;

  // Running hash value after reset and after each key.
  localparam logic [HashW-1:0] HashStart = 62'd1;

  // Bucket count after reset.
  localparam logic [BucketW-1:0] BucketCountReset = 32'd1024;

  // Largest hash that the reduction can give.
  localparam logic [HashW-1:0] HashMax = 62'h2000_0000_0000_000E;

  // The remainder unit retires one dividend bit per cycle.
  localparam int unsigned DivSteps = HashW;
  localparam int unsigned CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// File: sv/shbi_if.sv
// Valid/ready channel interfaces for the key bytes and for the hash results.
interface shbi_in_if;
  logic                           valid;
  logic                           ready;
  logic [shbi_pkg::KeyW-1:0]      key_byte;
  logic                           last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface shbi_out_if;
  logic                           valid;
  logic                           ready;
  logic [shbi_pkg::HashW-1:0]     hash_value;
  logic [shbi_pkg::BucketW-1:0]   bucket_index;

  modport source (output valid, output hash_value, output bucket_index, input ready);
  modport sink (input valid, input hash_value, input bucket_index, output ready);
endinterface

// File: sv/string_hash_bucket_index.sv
// Top level of the string hash bucket index block.
//
// The block hashes a key one byte word at a time as h = (h * 257 + byte) mod (2^61 + 15),
// starting from 1, with the product and sum wrapping at 64 bits. Each byte is accepted
// in the idle state, then passes a multiply-add state and a modular fold state. The
// last byte then runs a restoring remainder unit that retires one dividend bit per
// cycle, and the done state moves the result into the output register. The output
// register lets the next key's bytes be accepted while a result waits; when the next
// last byte has finished the remainder unit, it holds there with the input stalled
// until the previous result has been taken. A bucket count of zero gives a bucket
// index of zero. Write the bucket count only while the block is idle.
module string_hash_bucket_index (
  input  logic                           clk,
  input  logic                           rst_n,
  shbi_in_if.sink                        in_ch,
  shbi_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [shbi_pkg::BucketW-1:0]   cfg_wdata
);

  shbi_pkg::state_t state_r, state_nxt;

  logic [shbi_pkg::BucketW-1:0] bucket_count_r;
  logic [shbi_pkg::KeyW-1:0]    byte_r;
  logic                         last_r;
  logic [shbi_pkg::HashW-1:0]   run_hash_r;
  logic [shbi_pkg::ProdW-1:0]   prod_r;
  logic [shbi_pkg::HashW-1:0]   done_hash_r;
  logic [shbi_pkg::HashW-1:0]   div_sh_r;
  logic [shbi_pkg::BucketW-1:0] rem_r;
  logic [shbi_pkg::CntW-1:0]    cnt_r;
  logic                         out_valid_r;
  logic [shbi_pkg::HashW-1:0]   out_hash_r;
  logic [shbi_pkg::BucketW-1:0] out_index_r;

  logic in_take, out_take, out_load;

  logic [shbi_pkg::ProdW-1:0]   prod_nxt;
  logic [shbi_pkg::ProdW-1:0]   fold_diff;
  logic [shbi_pkg::HashW-1:0]   fold_hash;
  logic [shbi_pkg::BucketW:0]   rem_sh;
  logic [shbi_pkg::BucketW+1:0] trial;
  logic [shbi_pkg::BucketW-1:0] rem_nxt;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;

  // Multiply by 257 as a shift and add, then add the byte; all wraps at 64 bits.
  assign prod_nxt = (shbi_pkg::ProdW'(run_hash_r) << 8) + shbi_pkg::ProdW'(run_hash_r)
                  + shbi_pkg::ProdW'(byte_r);

  // Fold the bits above bit 61 back in: 2^61 is congruent to -15, and one add of the
  // modulus repairs a negative difference.
  always_comb begin
    fold_diff = shbi_pkg::ProdW'(prod_r[shbi_pkg::SplitW-1:0])
              - shbi_pkg::ProdW'(prod_r[shbi_pkg::ProdW-1:shbi_pkg::SplitW])
                * shbi_pkg::ProdW'(shbi_pkg::FoldFactor);
    if (fold_diff[shbi_pkg::ProdW-1]) begin
      fold_hash = shbi_pkg::HashW'(fold_diff + shbi_pkg::HashModulus);
    end else begin
      fold_hash = shbi_pkg::HashW'(fold_diff);
    end
  end

  // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_r, div_sh_r[shbi_pkg::HashW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, bucket_count_r};
    if (trial[shbi_pkg::BucketW+1]) begin
      rem_nxt = shbi_pkg::BucketW'(rem_sh);
    end else begin
      rem_nxt = shbi_pkg::BucketW'(trial);
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shbi_pkg::ST_IDLE: begin
        if (in_take) state_nxt = shbi_pkg::ST_MUL;
      end
      shbi_pkg::ST_MUL: begin
        state_nxt = shbi_pkg::ST_RED;
      end
      shbi_pkg::ST_RED: begin
        state_nxt = last_r ? shbi_pkg::ST_DIV : shbi_pkg::ST_IDLE;
      end
      shbi_pkg::ST_DIV: begin
        if (cnt_r == shbi_pkg::CntLast) state_nxt = shbi_pkg::ST_DONE;
      end
      shbi_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = shbi_pkg::ST_IDLE;
      end
      default: state_nxt = shbi_pkg::ST_IDLE;
    endcase
  end

  // Handshake and load controls of each state.
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      shbi_pkg::ST_IDLE: in_ch.ready = 1'b1;
      shbi_pkg::ST_DONE: out_load    = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  // Sequencer, running hash and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= shbi_pkg::ST_IDLE;
      run_hash_r     <= shbi_pkg::HashStart;
      bucket_count_r <= shbi_pkg::BucketCountReset;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bucket_count_r <= cfg_wdata;
      if (state_r == shbi_pkg::ST_RED) begin
        run_hash_r <= last_r ? shbi_pkg::HashStart : fold_hash;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers of the hash step and the remainder unit.
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.key_byte;
      last_r <= in_ch.last_byte;
    end
    if (state_r == shbi_pkg::ST_MUL) prod_r <= prod_nxt;
    if (state_r == shbi_pkg::ST_RED) begin
      done_hash_r <= fold_hash;
      div_sh_r    <= fold_hash;
      rem_r       <= '0;
      cnt_r       <= '0;
    end
    if (state_r == shbi_pkg::ST_DIV) begin
      rem_r    <= rem_nxt;
      div_sh_r <= div_sh_r << 1;
      cnt_r    <= cnt_r + 1'b1;
    end
    if (out_load) begin
      out_hash_r  <= done_hash_r;
      out_index_r <= (bucket_count_r == '0) ? '0 : rem_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hash_value   = out_hash_r;
  assign out_ch.bucket_index = out_index_r;

endmodule

// File: sv/shbi_checker.sv
// Port checker for the string hash bucket index block, with its bind statement.
module shbi_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [shbi_pkg::HashW-1:0]     hash_value,
  input logic [shbi_pkg::BucketW-1:0]   bucket_index
);

  // A result word that waits is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(hash_value) && $stable(bucket_index))
    else $error("result word changed while stalled");

  // The hash is fully reduced.
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hash_value <= shbi_pkg::HashMax)
    else $error("hash value not reduced");

  // A remainder never exceeds its dividend.
  a_index_le_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> shbi_pkg::HashW'(bucket_index) <= hash_value)
    else $error("bucket index larger than hash value");

  // A key byte accepted keeps the block busy for the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready during hash step");

endmodule

bind string_hash_bucket_index shbi_checker u_shbi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hash_value   (out_ch.hash_value),
  .bucket_index (out_ch.bucket_index)
);
